[rtl/core/mnrt_pkg.sv]
// ----------------------------------------------------------------------------
// mnrt_pkg
// Shared types, sizes and codes of the mesh neighbor and route table core.
// ----------------------------------------------------------------------------
package mnrt_pkg;

	localparam int NEIGHBOR_DEPTH = 32;
	localparam int ROUTE_DEPTH    = 32;
	localparam int ADDR_BITS      = 48;

	localparam int MAX_DEPTH = (NEIGHBOR_DEPTH > ROUTE_DEPTH) ? NEIGHBOR_DEPTH : ROUTE_DEPTH;
	localparam int NB_IDX_W  = $clog2(NEIGHBOR_DEPTH);
	localparam int RT_IDX_W  = $clog2(ROUTE_DEPTH);
	localparam int IDX_W     = $clog2(MAX_DEPTH);
	localparam int CNT_W     = $clog2(MAX_DEPTH + 1);

	localparam int BYTE_W          = 8;
	localparam int STATUS_W        = 3;
	localparam int ENTRY_INDEX_W   = 5;
	localparam int ENTRY_COUNT_W   = 6;
	localparam int CFG_INDEX_W     = 2;
	localparam int PRODUCT_W       = 2 * BYTE_W;
	localparam int METRIC_SUM_W    = PRODUCT_W + 2;

	localparam logic [BYTE_W-1:0] FULL_SUCCESS = 8'hFF;

	localparam logic [BYTE_W-1:0] SUCCESS_WEIGHT_RST = 8'd102;
	localparam logic [BYTE_W-1:0] RSSI_WEIGHT_RST    = 8'd77;
	localparam logic [BYTE_W-1:0] SNR_WEIGHT_RST     = 8'd77;

	localparam logic [CFG_INDEX_W-1:0] CFG_SUCCESS_WEIGHT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RSSI_WEIGHT    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SNR_WEIGHT     = 2'd2;

	typedef logic [ADDR_BITS-1:0] addr_t;

	typedef enum logic [0:0] {
		OP_HELLO = 1'b0,
		OP_ROUTE = 1'b1
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_NB_ADDED  = 3'd0,
		ST_NB_KNOWN  = 3'd1,
		ST_RT_ADDED  = 3'd2,
		ST_RT_EXISTS = 3'd3,
		ST_RT_OTHER  = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_SEARCH,
		CTL_RESULT
	} ctl_state_t;

	typedef struct packed {
		opcode_t           opcode;
		addr_t             source_addr;
		addr_t             dest_addr;
		logic [BYTE_W-1:0] sequence_num;
		logic [BYTE_W-1:0] rssi;
		logic [BYTE_W-1:0] snr;
		logic [BYTE_W-1:0] adv_metric;
	} in_word_t;

	typedef struct packed {
		status_t                  status;
		logic [ENTRY_INDEX_W-1:0] entry_index;
		logic [BYTE_W-1:0]        entry_metric;
		logic [ENTRY_COUNT_W-1:0] entry_count;
	} out_word_t;

	typedef struct packed {
		addr_t             address;
		logic [BYTE_W-1:0] last_seq;
		logic [BYTE_W-1:0] success;
		logic [BYTE_W-1:0] metric;
	} nb_entry_t;

	typedef struct packed {
		addr_t             destination;
		addr_t             next_hop;
		logic [BYTE_W-1:0] metric;
	} rt_entry_t;

endpackage

[rtl/core/mnrt_if.sv]
// ----------------------------------------------------------------------------
// mnrt_in_if / mnrt_out_if
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface mnrt_in_if;
	import mnrt_pkg::*;

	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mnrt_out_if;
	import mnrt_pkg::*;

	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/mnrt_ram.sv]
// ----------------------------------------------------------------------------
// mnrt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mnrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/mnrt_metric.sv]
// ----------------------------------------------------------------------------
// mnrt_metric
// Two-stage link metric: weighted products, then sum, shift and saturate.
// ----------------------------------------------------------------------------
module mnrt_metric (
	input  logic                       clk,
	input  logic                       load,
	input  logic [mnrt_pkg::BYTE_W-1:0] success_weight,
	input  logic [mnrt_pkg::BYTE_W-1:0] rssi_weight,
	input  logic [mnrt_pkg::BYTE_W-1:0] snr_weight,
	input  logic [mnrt_pkg::BYTE_W-1:0] rssi,
	input  logic [mnrt_pkg::BYTE_W-1:0] snr,
	output logic [mnrt_pkg::BYTE_W-1:0] metric
);
	import mnrt_pkg::*;

	logic [PRODUCT_W-1:0]    succ_prod_s1;
	logic [PRODUCT_W-1:0]    rssi_prod_s1;
	logic [PRODUCT_W-1:0]    snr_prod_s1;
	logic [METRIC_SUM_W-1:0] sum;
	logic [BYTE_W-1:0]       metric_s2;

	// capture products with the accepted word; weights are to hold while busy, which this block does not enforce
	always_ff @(posedge clk) begin
		if (load) begin
			succ_prod_s1 <= success_weight * FULL_SUCCESS;
			rssi_prod_s1 <= rssi_weight * rssi;
			snr_prod_s1  <= snr_weight * snr;
		end
	end

	assign sum = METRIC_SUM_W'(succ_prod_s1) + METRIC_SUM_W'(rssi_prod_s1)
	           + METRIC_SUM_W'(snr_prod_s1);

	always_ff @(posedge clk) begin
		if (|sum[METRIC_SUM_W-1:PRODUCT_W]) begin
			metric_s2 <= FULL_SUCCESS;
		end else begin
			metric_s2 <= sum[PRODUCT_W-1:BYTE_W];
		end
	end

	assign metric = metric_s2;

endmodule

[rtl/core/mesh_neighbor_route_table_core.sv]
// ----------------------------------------------------------------------------
// mesh_neighbor_route_table_core
// Neighbor and route tables of a mesh node with linear search and append.
// ----------------------------------------------------------------------------
// Search: a serial search over one RAM read port compares an accepted word
//   with up to count entries, count being the entries in the addressed table.
// Throughput: one word at a time; a new word is taken only after the result
//   of the last one has moved to the output register. A result may wait in
//   the output register while the next word is taken.
// Reset: counts clear to zero, weights load 102/77/77; RAM contents are not
//   cleared, entries past the count are never read.
// ----------------------------------------------------------------------------
module mesh_neighbor_route_table_core (
	input  logic                                clk,
	input  logic                                arst_n,
	mnrt_in_if.sink                             in_ch,
	mnrt_out_if.source                          out_ch,
	input  logic                                cfg_we,
	input  logic [mnrt_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mnrt_pkg::BYTE_W-1:0]         cfg_wdata
);
	import mnrt_pkg::*;

	// configuration
	logic [BYTE_W-1:0] success_weight_q;
	logic [BYTE_W-1:0] rssi_weight_q;
	logic [BYTE_W-1:0] snr_weight_q;

	// control
	ctl_state_t state_q;
	ctl_state_t state_d;
	logic [CNT_W-1:0] nb_cnt_q;
	logic [CNT_W-1:0] rt_cnt_q;
	logic [CNT_W-1:0] iss_q;
	logic             rd_valid_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             found_q;
	logic             out_valid_q;

	// held word and match record
	in_word_t          item_q;
	logic [IDX_W-1:0]  match_idx_q;
	logic [BYTE_W-1:0] match_metric_q;
	logic              hop_eq_q;
	out_word_t         out_data_q;

	logic              in_fire;
	logic [CNT_W-1:0]  lim;
	logic [CNT_W-1:0]  lim_depth;
	logic              issue;
	logic              hit;
	logic              search_done;
	logic              out_free;
	logic              leave;
	logic              full;
	logic              nb_we;
	logic              rt_we;
	out_word_t         result;
	nb_entry_t         nb_wdata;
	nb_entry_t         nb_rdata;
	rt_entry_t         rt_wdata;
	rt_entry_t         rt_rdata;
	logic [BYTE_W-1:0] new_metric;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == CTL_IDLE);
	assign out_free = !out_valid_q || out_ch.ready;
	assign leave    = (state_q == CTL_RESULT) && out_free;

	// search limit and capacity of the addressed table
	assign lim       = (item_q.opcode == OP_ROUTE) ? rt_cnt_q : nb_cnt_q;
	assign lim_depth = (item_q.opcode == OP_ROUTE) ? CNT_W'(ROUTE_DEPTH)
	                                               : CNT_W'(NEIGHBOR_DEPTH);
	assign full      = (lim >= lim_depth);

	// compare the entry read last cycle; stop issuing once it hits
	always_comb begin
		if (item_q.opcode == OP_ROUTE) begin
			hit = rd_valid_s1 && (rt_rdata.destination == item_q.dest_addr);
		end else begin
			hit = rd_valid_s1 && (nb_rdata.address == item_q.source_addr);
		end
	end

	assign issue       = (state_q == CTL_SEARCH) && !hit && (iss_q < lim);
	assign search_done = (state_q == CTL_SEARCH) && !rd_valid_s1 && (iss_q >= lim);

	// -- memories ------------------------------------------------------------
	// Inserts are written only when the word leaves, and the next search
	// starts after that, so no read can meet a pending write.
	assign nb_wdata.address  = item_q.source_addr;
	assign nb_wdata.last_seq = item_q.sequence_num;
	assign nb_wdata.success  = FULL_SUCCESS;
	assign nb_wdata.metric   = new_metric;

	assign rt_wdata.destination = item_q.dest_addr;
	assign rt_wdata.next_hop    = item_q.source_addr;
	assign rt_wdata.metric      = item_q.adv_metric;

	mnrt_ram #(
		.WIDTH ($bits(nb_entry_t)),
		.DEPTH (NEIGHBOR_DEPTH)
	) u_nb_ram (
		.clk   (clk),
		.we    (nb_we),
		.waddr (NB_IDX_W'(nb_cnt_q)),
		.wdata (nb_wdata),
		.raddr (NB_IDX_W'(iss_q)),
		.rdata (nb_rdata)
	);

	mnrt_ram #(
		.WIDTH ($bits(rt_entry_t)),
		.DEPTH (ROUTE_DEPTH)
	) u_rt_ram (
		.clk   (clk),
		.we    (rt_we),
		.waddr (RT_IDX_W'(rt_cnt_q)),
		.wdata (rt_wdata),
		.raddr (RT_IDX_W'(iss_q)),
		.rdata (rt_rdata)
	);

	// metric for a new neighbor: products are registered on accept, then the saturated metric
	mnrt_metric u_metric (
		.clk            (clk),
		.load           (in_fire),
		.success_weight (success_weight_q),
		.rssi_weight    (rssi_weight_q),
		.snr_weight     (snr_weight_q),
		.rssi           (in_ch.data.rssi),
		.snr            (in_ch.data.snr),
		.metric         (new_metric)
	);

	// -- configuration -------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			success_weight_q <= SUCCESS_WEIGHT_RST;
			rssi_weight_q    <= RSSI_WEIGHT_RST;
			snr_weight_q     <= SNR_WEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SUCCESS_WEIGHT: success_weight_q <= cfg_wdata;
				CFG_RSSI_WEIGHT:    rssi_weight_q    <= cfg_wdata;
				CFG_SNR_WEIGHT:     snr_weight_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// -- sequencer -----------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CTL_IDLE: begin
				if (in_fire) begin
					state_d = CTL_SEARCH;
				end
			end
			CTL_SEARCH: begin
				if (hit || search_done) begin
					state_d = CTL_RESULT;
				end
			end
			CTL_RESULT: begin
				if (out_free) begin
					state_d = CTL_IDLE;
				end
			end
			default: state_d = CTL_IDLE;
		endcase
	end

	// result word and insert enables
	always_comb begin
		result = '0;
		nb_we  = 1'b0;
		rt_we  = 1'b0;
		if (found_q) begin
			result.entry_index  = ENTRY_INDEX_W'(match_idx_q);
			result.entry_metric = match_metric_q;
			result.entry_count  = ENTRY_COUNT_W'(lim);
			if (item_q.opcode == OP_ROUTE) begin
				result.status = hop_eq_q ? ST_RT_EXISTS : ST_RT_OTHER;
			end else begin
				result.status = ST_NB_KNOWN;
			end
		end else if (full) begin
			result.status      = ST_FULL;
			result.entry_count = ENTRY_COUNT_W'(lim);
		end else begin
			result.entry_index = ENTRY_INDEX_W'(lim);
			result.entry_count = ENTRY_COUNT_W'(lim + CNT_W'(1));
			if (item_q.opcode == OP_ROUTE) begin
				result.status       = ST_RT_ADDED;
				result.entry_metric = item_q.adv_metric;
				rt_we               = leave;
			end else begin
				result.status       = ST_NB_ADDED;
				result.entry_metric = new_metric;
				nb_we               = leave;
			end
		end
	end

	// search counters, table counts and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_cnt_q    <= '0;
			rt_cnt_q    <= '0;
			iss_q       <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (in_fire) begin
				iss_q   <= '0;
				found_q <= 1'b0;
			end else if (issue) begin
				iss_q <= iss_q + CNT_W'(1);
			end
			if (hit) begin
				found_q <= 1'b1;
			end
			if (nb_we) begin
				nb_cnt_q <= nb_cnt_q + CNT_W'(1);
			end
			if (rt_we) begin
				rt_cnt_q <= rt_cnt_q + CNT_W'(1);
			end
			if (leave) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: held word, match record, output word
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q <= in_ch.data;
		end
		if (issue) begin
			rd_idx_s1 <= IDX_W'(iss_q);
		end
		if (hit) begin
			match_idx_q <= rd_idx_s1;
			if (item_q.opcode == OP_ROUTE) begin
				match_metric_q <= rt_rdata.metric;
				hop_eq_q       <= (rt_rdata.next_hop == item_q.source_addr);
			end else begin
				match_metric_q <= nb_rdata.metric;
				hop_eq_q       <= 1'b0;
			end
		end
		if (leave) begin
			out_data_q <= result;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

endmodule
